### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of the core.
// No dependencies; take in with `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define YR_ASSERT_NOW(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Check that a condition at one edge implies another at the next edge.
`define YR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/yuvrgb_pkg.sv
// Types and constants for the YUV 4:2:0 block to RGB converter.
// No dependencies; used by the modules, interfaces and checker of the core.
package yuvrgb_pkg;

    localparam int LANES = 4;
    localparam int POS_W = $clog2(LANES);

    typedef logic [7:0]          chan_t;
    typedef logic signed [16:0]  prod_t;
    typedef logic [POS_W-1:0]    pos_t;

    // Chroma products shared by the four pixels of a block.
    typedef struct packed {
        prod_t blue;   // 454 * (U - 128)
        prod_t red;    // 359 * (V - 128)
        prod_t green;  // 183 * (V - 128) + 88 * (U - 128)
    } chroma_terms_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } rgb_t;

    localparam pos_t POS_TOP_LEFT     = 2'd0;
    localparam pos_t POS_TOP_RIGHT    = 2'd1;
    localparam pos_t POS_BOTTOM_LEFT  = 2'd2;
    localparam pos_t POS_BOTTOM_RIGHT = 2'd3;

    localparam logic MODE_SPLIT = 1'b0;
    localparam logic MODE_JOINT = 1'b1;

    localparam logic signed [9:0] COEF_U_BLUE  = 10'sd454;
    localparam logic signed [9:0] COEF_V_RED   = 10'sd359;
    localparam logic signed [9:0] COEF_V_GREEN = 10'sd183;
    localparam logic signed [9:0] COEF_U_GREEN = 10'sd88;

    localparam logic signed [8:0] CHROMA_BIAS = 9'sd128;
    localparam chan_t             LUMA_BIAS   = 8'd16;
    localparam chan_t             CHAN_MAX    = 8'd255;

endpackage

### rtl/core/yuvrgb_if.sv
// Channel interfaces of the converter: 2x2 block in, one pixel per word out.
// Depends on yuvrgb_pkg.
interface yuvrgb_block_if;
    logic                 valid;
    logic                 ready;
    yuvrgb_pkg::chan_t    luma_top_left;
    yuvrgb_pkg::chan_t    luma_top_right;
    yuvrgb_pkg::chan_t    luma_bottom_left;
    yuvrgb_pkg::chan_t    luma_bottom_right;
    yuvrgb_pkg::chan_t    chroma_blue;
    yuvrgb_pkg::chan_t    chroma_red;

    modport source (
        output valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_blue, chroma_red,
        input  ready
    );
    modport sink (
        input  valid, luma_top_left, luma_top_right, luma_bottom_left,
               luma_bottom_right, chroma_blue, chroma_red,
        output ready
    );
endinterface

interface yuvrgb_pixel_if;
    logic                 valid;
    logic                 ready;
    yuvrgb_pkg::chan_t    red;
    yuvrgb_pkg::chan_t    green;
    yuvrgb_pkg::chan_t    blue;
    yuvrgb_pkg::pos_t     pixel_position;
    logic                 last;

    modport source (
        output valid, red, green, blue, pixel_position, last,
        input  ready
    );
    modport sink (
        input  valid, red, green, blue, pixel_position, last,
        output ready
    );
endinterface

### rtl/core/yuvrgb_front.sv
// Front stage: removes the chroma bias and forms the shared chroma products.
// Depends on yuvrgb_pkg.
module yuvrgb_front (
    input  logic                                         clk,
    input  logic                                         load,
    input  yuvrgb_pkg::chan_t [yuvrgb_pkg::LANES-1:0]    luma_in,
    input  yuvrgb_pkg::chan_t                            chroma_blue,
    input  yuvrgb_pkg::chan_t                            chroma_red,
    output yuvrgb_pkg::chan_t [yuvrgb_pkg::LANES-1:0]    luma_out,
    output yuvrgb_pkg::chroma_terms_t                    terms
);

    logic signed [8:0]                           u;
    logic signed [8:0]                           v;
    yuvrgb_pkg::chroma_terms_t                   terms_next;
    yuvrgb_pkg::chroma_terms_t                   terms_reg;
    yuvrgb_pkg::chan_t [yuvrgb_pkg::LANES-1:0]   luma_reg;

    assign u = $signed({1'b0, chroma_blue}) - yuvrgb_pkg::CHROMA_BIAS;
    assign v = $signed({1'b0, chroma_red}) - yuvrgb_pkg::CHROMA_BIAS;

    always_comb
    begin
        terms_next.blue  = yuvrgb_pkg::prod_t'(u)
                         * yuvrgb_pkg::prod_t'(yuvrgb_pkg::COEF_U_BLUE);
        terms_next.red   = yuvrgb_pkg::prod_t'(v)
                         * yuvrgb_pkg::prod_t'(yuvrgb_pkg::COEF_V_RED);
        terms_next.green = yuvrgb_pkg::prod_t'(v)
                         * yuvrgb_pkg::prod_t'(yuvrgb_pkg::COEF_V_GREEN)
                         + yuvrgb_pkg::prod_t'(u)
                         * yuvrgb_pkg::prod_t'(yuvrgb_pkg::COEF_U_GREEN);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg <= terms_next;
            luma_reg  <= luma_in;
        end
    end

    assign terms    = terms_reg;
    assign luma_out = luma_reg;

endmodule

### rtl/core/yuvrgb_lane.sv
// One pixel lane: adds luma to the chroma terms, shifts and clamps.
// Depends on yuvrgb_pkg.
module yuvrgb_lane (
    input  logic                        clk,
    input  logic                        load,
    input  logic                        mode,
    input  yuvrgb_pkg::chan_t           luma,
    input  yuvrgb_pkg::chroma_terms_t   terms,
    output yuvrgb_pkg::rgb_t            pixel
);

    typedef logic signed [18:0] wide_t;

    wide_t              y_ext;
    wide_t              yy;
    wide_t              red_sum;
    wide_t              green_sum;
    wide_t              blue_sum;
    yuvrgb_pkg::rgb_t   pixel_next;
    yuvrgb_pkg::rgb_t   pixel_reg;

    function automatic yuvrgb_pkg::chan_t clamp(input wide_t x);
        yuvrgb_pkg::chan_t res;
        if (x < 0)
            res = '0;
        else if (x > wide_t'(yuvrgb_pkg::CHAN_MAX))
            res = yuvrgb_pkg::CHAN_MAX;
        else
            res = x[7:0];
        return res;
    endfunction

    assign y_ext = wide_t'(luma);
    assign yy    = (y_ext - wide_t'(yuvrgb_pkg::LUMA_BIAS)) <<< 8;

    always_comb
    begin
        unique case (mode)
            yuvrgb_pkg::MODE_SPLIT:
            begin
                // Shift each chroma term on its own, then add raw luma.
                red_sum   = y_ext + wide_t'(terms.red >>> 8);
                green_sum = y_ext - wide_t'(terms.green >>> 8);
                blue_sum  = y_ext + wide_t'(terms.blue >>> 8);
            end
            yuvrgb_pkg::MODE_JOINT:
            begin
                red_sum   = (yy + wide_t'(terms.red)) >>> 8;
                green_sum = (yy - wide_t'(terms.green)) >>> 8;
                blue_sum  = (yy + wide_t'(terms.blue)) >>> 8;
            end
            default:
            begin
                red_sum   = '0;
                green_sum = '0;
                blue_sum  = '0;
            end
        endcase
        pixel_next.red   = clamp(red_sum);
        pixel_next.green = clamp(green_sum);
        pixel_next.blue  = clamp(blue_sum);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pixel_reg <= pixel_next;
    end

    assign pixel = pixel_reg;

endmodule

### rtl/core/yuvrgb_merge.sv
// Merge stage: holds the four lane results and sends them one word a cycle while the receiver is ready.
// Depends on yuvrgb_pkg and yuvrgb_pixel_if.
module yuvrgb_merge (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       load,
    input  yuvrgb_pkg::rgb_t [yuvrgb_pkg::LANES-1:0]   pixels,
    output logic                                       can_load,
    yuvrgb_pixel_if.source                             pix
);

    yuvrgb_pkg::rgb_t [yuvrgb_pkg::LANES-1:0]   buf_reg;
    logic                                       valid_reg;
    yuvrgb_pkg::pos_t                           pos_reg;
    logic                                       is_last;
    logic                                       pop;

    assign is_last  = (pos_reg == yuvrgb_pkg::POS_BOTTOM_RIGHT);
    assign pop      = valid_reg && pix.ready;
    // Take the next block while the final word of this one leaves.
    assign can_load = !valid_reg || (pop && is_last);

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= pixels;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= yuvrgb_pkg::POS_TOP_LEFT;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            pos_reg   <= yuvrgb_pkg::POS_TOP_LEFT;
        end
        else if (pop)
        begin
            if (is_last)
                valid_reg <= 1'b0;
            pos_reg <= pos_reg + 1'b1;
        end
    end

    assign pix.valid          = valid_reg;
    assign pix.red            = buf_reg[pos_reg].red;
    assign pix.green          = buf_reg[pos_reg].green;
    assign pix.blue           = buf_reg[pos_reg].blue;
    assign pix.pixel_position = pos_reg;
    assign pix.last           = is_last;

endmodule

### rtl/core/yuv420_block_to_rgb.sv
// YUV 4:2:0 2x2 block to RGB: front stage, four pixel lanes, merge stage.
// A block passes the front registers, the lane registers and the merge buffer
// before its first pixel word is valid. The merge stage sends one pixel word per
// cycle while the receiver is ready; up to three blocks are in flight.
// Reset: asynchronous, active low; empties the pipe and sets mode_reg to 0.
module yuv420_block_to_rgb (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    yuvrgb_block_if.sink      blk,
    yuvrgb_pixel_if.source    pix
);

    logic                                        mode_reg;
    logic                                        s1_valid_reg;
    logic                                        s2_valid_reg;
    logic                                        s1_ready;
    logic                                        s2_ready;
    logic                                        merge_ready;
    logic                                        front_load;
    logic                                        lane_load;
    logic                                        merge_load;
    yuvrgb_pkg::chan_t [yuvrgb_pkg::LANES-1:0]   luma_in;
    yuvrgb_pkg::chan_t [yuvrgb_pkg::LANES-1:0]   luma_s1;
    yuvrgb_pkg::chroma_terms_t                   terms_s1;
    yuvrgb_pkg::rgb_t [yuvrgb_pkg::LANES-1:0]    pixels_s2;

    assign s2_ready   = !s2_valid_reg || merge_ready;
    assign s1_ready   = !s1_valid_reg || s2_ready;
    assign blk.ready  = s1_ready;
    assign front_load = blk.valid && s1_ready;
    assign lane_load  = s1_valid_reg && s2_ready;
    assign merge_load = s2_valid_reg && merge_ready;

    assign luma_in[yuvrgb_pkg::POS_TOP_LEFT]     = blk.luma_top_left;
    assign luma_in[yuvrgb_pkg::POS_TOP_RIGHT]    = blk.luma_top_right;
    assign luma_in[yuvrgb_pkg::POS_BOTTOM_LEFT]  = blk.luma_bottom_left;
    assign luma_in[yuvrgb_pkg::POS_BOTTOM_RIGHT] = blk.luma_bottom_right;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= yuvrgb_pkg::MODE_SPLIT;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                mode_reg <= cfg_wdata;
            if (s1_ready)
                s1_valid_reg <= blk.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    yuvrgb_front u_front (
        .clk         (clk),
        .load        (front_load),
        .luma_in     (luma_in),
        .chroma_blue (blk.chroma_blue),
        .chroma_red  (blk.chroma_red),
        .luma_out    (luma_s1),
        .terms       (terms_s1)
    );

    for (genvar k = 0; k < yuvrgb_pkg::LANES; k++)
    begin : g_lane
        yuvrgb_lane u_lane (
            .clk   (clk),
            .load  (lane_load),
            .mode  (mode_reg),
            .luma  (luma_s1[k]),
            .terms (terms_s1),
            .pixel (pixels_s2[k])
        );
    end

    yuvrgb_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (merge_load),
        .pixels   (pixels_s2),
        .can_load (merge_ready),
        .pix      (pix)
    );

endmodule

### rtl/core/yuvrgb_checker.sv
// Port-level checks for yuv420_block_to_rgb, attached by bind.
// Depends on yuvrgb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module yuvrgb_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input yuvrgb_pkg::chan_t    out_red,
    input yuvrgb_pkg::chan_t    out_green,
    input yuvrgb_pkg::chan_t    out_blue,
    input yuvrgb_pkg::pos_t     out_pos,
    input logic                 out_last
);

    localparam logic [2:0] MAX_BLOCKS = 3'd3;

    logic               in_acc;
    logic               out_acc;
    logic               done;
    logic [2:0]         pending_reg;
    logic [2:0]         pending_next;
    yuvrgb_pkg::pos_t   exp_pos_reg;

    assign in_acc       = in_valid && in_ready;
    assign out_acc      = out_valid && out_ready;
    assign done         = out_acc && out_last;
    assign pending_next = 3'(pending_reg + 3'(in_acc) - 3'(done));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            exp_pos_reg <= yuvrgb_pkg::POS_TOP_LEFT;
        end
        else
        begin
            pending_reg <= pending_next;
            if (out_acc)
                exp_pos_reg <= exp_pos_reg + 1'b1;
        end
    end

    `YR_ASSERT_NOW(a_last_pos, clk, rst_n,
        !out_valid || (out_last == (out_pos == yuvrgb_pkg::POS_BOTTOM_RIGHT)),
        "last flag does not match bottom-right position")

    `YR_ASSERT_NOW(a_pos_order, clk, rst_n,
        !out_valid || (out_pos == exp_pos_reg),
        "pixel positions out of order")

    `YR_ASSERT_NOW(a_no_orphan, clk, rst_n,
        (!out_valid || (pending_reg != 3'd0)) && (pending_reg <= MAX_BLOCKS),
        "output word without a pending block, or too many blocks in flight")

    `YR_ASSERT_NEXT(a_out_hold, clk, rst_n,
        out_valid && !out_ready,
        out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue)
            && $stable(out_pos) && $stable(out_last),
        "stalled output word changed")

endmodule

bind yuv420_block_to_rgb yuvrgb_checker u_yuvrgb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (blk.valid),
    .in_ready  (blk.ready),
    .out_valid (pix.valid),
    .out_ready (pix.ready),
    .out_red   (pix.red),
    .out_green (pix.green),
    .out_blue  (pix.blue),
    .out_pos   (pix.pixel_position),
    .out_last  (pix.last)
);

### verif/yuv420_block_to_rgb_tb.sv
// Self-checking bench for yuv420_block_to_rgb: corner and random 2x2 blocks go in
// under both formula modes, and every pixel word is checked against an integer model.
// Depends on yuvrgb_pkg, the channel interfaces in yuvrgb_if and the block's RTL.
module yuv420_block_to_rgb_tb;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int IDLE_PCT       = 20;
    localparam int PHASES         = 6;
    localparam int PHASE_BLOCKS   = 50;
    localparam int CALM_FROM      = 120;
    localparam int CALM_TO        = 170;
    localparam int SQUEEZE_AT     = 200;
    localparam int SQUEEZE_CYCLES = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int REPORT_MAX     = 10;

    localparam int GAIN_U_BLUE  = 454;
    localparam int GAIN_V_RED   = 359;
    localparam int GAIN_V_GREEN = 183;
    localparam int GAIN_U_GREEN = 88;
    localparam int CHROMA_MID   = 128;
    localparam int LUMA_FLOOR   = 16;
    localparam int CHAN_TOP     = 255;

    typedef struct {
        yuvrgb_pkg::chan_t luma [4];
        yuvrgb_pkg::chan_t chroma_blue;
        yuvrgb_pkg::chan_t chroma_red;
    } yuv_block_t;

    typedef struct {
        yuvrgb_pkg::chan_t red;
        yuvrgb_pkg::chan_t green;
        yuvrgb_pkg::chan_t blue;
        yuvrgb_pkg::pos_t  pixel_position;
        logic              last;
    } pixel_t;

    class pixel_tally;
        logic   mode;
        pixel_t due [$];
        int     blocks_in;
        int     pixels_out;
        int     faults;

        function new();
            mode       = yuvrgb_pkg::MODE_SPLIT;
            blocks_in  = 0;
            pixels_out = 0;
            faults     = 0;
        endfunction

        function yuvrgb_pkg::chan_t clamp_byte(int x);
            if (x < 0)
                return '0;
            if (x > CHAN_TOP)
                return yuvrgb_pkg::chan_t'(CHAN_TOP);
            return yuvrgb_pkg::chan_t'(x);
        endfunction

        // Expected pixel k of a block under the current formula mode.
        function pixel_t rgb_of_block(yuv_block_t blkv, int k);
            int     u;
            int     v;
            int     y;
            int     r;
            int     g;
            int     bl;
            int     yy;
            pixel_t px;
            u = int'(blkv.chroma_blue) - CHROMA_MID;
            v = int'(blkv.chroma_red) - CHROMA_MID;
            y = int'(blkv.luma[k]);
            if (mode == yuvrgb_pkg::MODE_SPLIT)
            begin
                r  = y + ((v * GAIN_V_RED) >>> 8);
                g  = y - ((v * GAIN_V_GREEN + u * GAIN_U_GREEN) >>> 8);
                bl = y + ((u * GAIN_U_BLUE) >>> 8);
            end
            else
            begin
                yy = (y - LUMA_FLOOR) * 256;
                r  = (yy + v * GAIN_V_RED) >>> 8;
                g  = (yy - u * GAIN_U_GREEN - v * GAIN_V_GREEN) >>> 8;
                bl = (yy + u * GAIN_U_BLUE) >>> 8;
            end
            px.red            = clamp_byte(r);
            px.green          = clamp_byte(g);
            px.blue           = clamp_byte(bl);
            px.pixel_position = yuvrgb_pkg::pos_t'(k);
            px.last           = (k == 3);
            return px;
        endfunction

        function void note_block(yuv_block_t blkv);
            int k;
            for (k = 0; k < 4; k++)
                due.push_back(rgb_of_block(blkv, k));
            blocks_in++;
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (due.size() == 0)
            begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("pixel word with nothing due: pos %0d rgb %0d %0d %0d last %0b",
                             got.pixel_position, got.red, got.green, got.blue, got.last);
                return;
            end
            want = due.pop_front();
            pixels_out++;
            if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
                got.pixel_position !== want.pixel_position || got.last !== want.last)
            begin
                faults++;
                if (faults <= REPORT_MAX)
                    $display("mismatch at %0t: exp %0d:%0d/%0d/%0d/%0b got %0d:%0d/%0d/%0d/%0b",
                             $time, want.pixel_position, want.red, want.green, want.blue,
                             want.last, got.pixel_position, got.red, got.green, got.blue,
                             got.last);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   mode_writes;

    yuvrgb_block_if blk_ch ();
    yuvrgb_pixel_if pix_ch ();

    pixel_tally tally = new();

    yuv420_block_to_rgb u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .blk       (blk_ch),
        .pix       (pix_ch)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // No idling on either side while this window of blocks goes through.
    function automatic bit calm_now();
        return tally.blocks_in >= CALM_FROM && tally.blocks_in < CALM_TO;
    endfunction

    function automatic yuv_block_t make_block(yuvrgb_pkg::chan_t y0, yuvrgb_pkg::chan_t y1,
                                              yuvrgb_pkg::chan_t y2, yuvrgb_pkg::chan_t y3,
                                              yuvrgb_pkg::chan_t u, yuvrgb_pkg::chan_t v);
        yuv_block_t blkv;
        blkv.luma[0]     = y0;
        blkv.luma[1]     = y1;
        blkv.luma[2]     = y2;
        blkv.luma[3]     = y3;
        blkv.chroma_blue = u;
        blkv.chroma_red  = v;
        return blkv;
    endfunction

    // Lean toward the values where clamping and rounding turn over.
    function automatic yuvrgb_pkg::chan_t pick_byte();
        unique case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return yuvrgb_pkg::chan_t'(CHROMA_MID);
            3:       return yuvrgb_pkg::chan_t'(CHROMA_MID - 1);
            default: return yuvrgb_pkg::chan_t'($urandom);
        endcase
    endfunction

    function automatic yuv_block_t random_block();
        return make_block(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                          pick_byte(), pick_byte());
    endfunction

    // Call at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_block(yuv_block_t blkv);
        while (!calm_now() && $urandom_range(99) < IDLE_PCT)
        begin
            blk_ch.valid = 1'b0;
            @(negedge clk);
        end
        blk_ch.valid             = 1'b1;
        blk_ch.luma_top_left     = blkv.luma[0];
        blk_ch.luma_top_right    = blkv.luma[1];
        blk_ch.luma_bottom_left  = blkv.luma[2];
        blk_ch.luma_bottom_right = blkv.luma[3];
        blk_ch.chroma_blue       = blkv.chroma_blue;
        blk_ch.chroma_red        = blkv.chroma_red;
        @(posedge clk);
        while (!blk_ch.ready)
            @(posedge clk);
        tally.note_block(blkv);
        @(negedge clk);
    endtask

    task automatic drain_pixels();
        blk_ch.valid = 1'b0;
        while (tally.due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the mode only once the pipe is empty.
    task automatic write_mode(logic m);
        drain_pixels();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = m;
        @(posedge clk);
        tally.mode = m;
        mode_writes++;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    always @(posedge clk)
    begin
        pixel_t got;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            got.red            = pix_ch.red;
            got.green          = pix_ch.green;
            got.blue           = pix_ch.blue;
            got.pixel_position = pix_ch.pixel_position;
            got.last           = pix_ch.last;
            tally.check_pixel(got);
        end
    end

    // Receiver: random stalls, one long hold-off to back the pipe up.
    initial
    begin
        bit squeezed;
        squeezed     = 1'b0;
        pix_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!squeezed && tally.blocks_in >= SQUEEZE_AT)
            begin
                squeezed     = 1'b1;
                pix_ch.ready = 1'b0;
                repeat (SQUEEZE_CYCLES) @(negedge clk);
            end
            pix_ch.ready = calm_now() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d pixel words still due",
                 cycles, tally.due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        yuv_block_t corners [$];
        int         p;
        int         i;
        rst_n                    = 1'b0;
        cfg_we                   = 1'b0;
        cfg_wdata                = yuvrgb_pkg::MODE_SPLIT;
        mode_writes              = 0;
        blk_ch.valid             = 1'b0;
        blk_ch.luma_top_left     = '0;
        blk_ch.luma_top_right    = '0;
        blk_ch.luma_bottom_left  = '0;
        blk_ch.luma_bottom_right = '0;
        blk_ch.chroma_blue       = '0;
        blk_ch.chroma_red        = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        corners = '{
            make_block(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0),
            make_block(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255),
            make_block(8'd0,   8'd255, 8'd0,   8'd255, 8'd128, 8'd128),
            make_block(8'd16,  8'd235, 8'd128, 8'd1,   8'd0,   8'd255),
            make_block(8'd255, 8'd254, 8'd1,   8'd0,   8'd255, 8'd0),
            make_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd255, 8'd255),
            make_block(8'd128, 8'd128, 8'd128, 8'd128, 8'd0,   8'd0),
            make_block(8'h55,  8'haa,  8'h0f,  8'hf0,  8'h55,  8'haa),
            make_block(8'd16,  8'd16,  8'd16,  8'd16,  8'd127, 8'd129),
            make_block(8'd200, 8'd50,  8'd100, 8'd150, 8'd129, 8'd127)
        };

        write_mode(yuvrgb_pkg::MODE_SPLIT);
        for (i = 0; i < corners.size(); i++)
            send_block(corners[i]);
        write_mode(yuvrgb_pkg::MODE_JOINT);
        for (i = 0; i < corners.size(); i++)
            send_block(corners[i]);

        // Alternate modes; each write waits for the pipe to empty.
        for (p = 0; p < PHASES; p++)
        begin
            write_mode(p[0] ? yuvrgb_pkg::MODE_JOINT : yuvrgb_pkg::MODE_SPLIT);
            for (i = 0; i < PHASE_BLOCKS; i++)
                send_block(random_block());
        end

        drain_pixels();
        $display("covered %0d blocks, %0d pixel words checked, %0d mode writes",
                 tally.blocks_in, tally.pixels_out, mode_writes);
        $display("both formulas, clamping at both ends, one long output stall; %0d mismatches",
                 tally.faults);
        if (tally.faults == 0 && tally.due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/yuvrgb_pkg.sv
rtl/core/yuvrgb_if.sv
rtl/core/yuvrgb_front.sv
rtl/core/yuvrgb_lane.sv
rtl/core/yuvrgb_merge.sv
rtl/core/yuv420_block_to_rgb.sv
rtl/core/yuvrgb_checker.sv
verif/yuv420_block_to_rgb_tb.sv
